/* rtl/rcst_pkg.sv */
// Shared types and constants of the reference-counted sorted table.
// Holds the entry layout, operation and status codes and the
// controller/datapath command and status structs. No dependencies.
package rcst_pkg;

    // Table geometry
    localparam int CAPACITY = 256;
    localparam int IDX_W    = $clog2(CAPACITY);
    localparam int CNT_W    = $clog2(CAPACITY + 1);

    // Field widths
    localparam int OP_W   = 2;
    localparam int KEY_W  = 16;
    localparam int VAL_W  = 32;
    localparam int ICNT_W = 16;
    localparam int REF_W  = 16;
    localparam int ST_W   = 3;

    typedef enum logic [OP_W-1:0] {
        OP_INSERT = 2'd0,
        OP_REMOVE = 2'd1,
        OP_LOOKUP = 2'd2,
        OP_NONE   = 2'd3
    } op_t;

    typedef enum logic [ST_W-1:0] {
        ST_ADDED  = 3'd0,
        ST_BUMPED = 3'd1,
        ST_FULL   = 3'd2,
        ST_FREED  = 3'd3,
        ST_HELD   = 3'd4,
        ST_ABSENT = 3'd5,
        ST_HIT    = 3'd6,
        ST_MISS   = 3'd7
    } status_t;

    // One table entry as stored in the memory
    typedef struct packed {
        logic [KEY_W-1:0]  key;
        logic [VAL_W-1:0]  value;
        logic [ICNT_W-1:0] count;
        logic [REF_W-1:0]  refs;
    } entry_t;

    // Controller to datapath
    typedef struct packed {
        logic    latch_in;
        logic    search_init;
        logic    search_rd;
        logic    search_cmp;
        logic    shift_init;
        logic    shift_up;
        logic    shift_rd;
        logic    shift_wr;
        logic    write_new;
        logic    write_ref;
        logic    ref_inc;
        logic    used_dec;
        logic    load_out;
        status_t out_status;
    } dp_cmd_t;

    // Datapath to controller
    typedef struct packed {
        op_t  op;
        logic search_done;
        logic hit;
        logic full;
        logic ref_last;
        logic shift_done;
        logic out_free;
    } dp_stat_t;

endpackage

/* rtl/rcst_if.sv */
// Valid/ready channel interfaces for the sorted table's request and
// response streams. Depends on rcst_pkg for field widths.
interface rcst_req_if import rcst_pkg::*;;
    logic              valid;
    logic              ready;
    logic [OP_W-1:0]   op;
    logic [KEY_W-1:0]  key;
    logic [VAL_W-1:0]  entry_value;
    logic [ICNT_W-1:0] entry_count;

    modport source (output valid, output op, output key, output entry_value,
                    output entry_count, input ready);
    modport sink   (input valid, input op, input key, input entry_value,
                    input entry_count, output ready);
endinterface

interface rcst_rsp_if import rcst_pkg::*;;
    logic              valid;
    logic              ready;
    logic [ST_W-1:0]   status;
    logic [VAL_W-1:0]  out_value;
    logic [ICNT_W-1:0] out_count;

    modport source (output valid, output status, output out_value,
                    output out_count, input ready);
    modport sink   (input valid, input status, input out_value,
                    input out_count, output ready);
endinterface

/* rtl/refcounted_sorted_table.sv */
// Top level of the reference-counted sorted table: joins the controller
// and the datapath to the request and response channels.
// Depends on rcst_pkg, rcst_if, rcst_ctrl and rcst_dpath.
//
//   channel  modport  fields
//   req      sink     op, key, entry_value, entry_count
//   rsp      source   status, out_value, out_count
//
// Each request runs a binary search of S probes and, on an insert that adds an
// entry or a freeing remove, M moves; the controller is back in idle and takes
// the next request as soon as the response is loaded. S <= clog2(entries+1)
// and M is the number of entries moved up or down one slot. The entry
// memory has one write and one registered read port; one probe or one move
// each needs a read and then a compare or a write.
// Reset clears the entry count; the memory itself is not cleared.
// A waiting response sits in the output register and the next request
// is accepted meanwhile; only its own response waits for that register.
module refcounted_sorted_table import rcst_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    rcst_req_if.sink   req,
    rcst_rsp_if.source rsp
);

    dp_cmd_t  cmd;
    dp_stat_t stat;

    rcst_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req.valid),
        .req_ready (req.ready),
        .stat      (stat),
        .cmd       (cmd)
    );

    rcst_dpath u_dpath (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd),
        .stat       (stat),
        .req_op     (req.op),
        .req_key    (req.key),
        .req_value  (req.entry_value),
        .req_count  (req.entry_count),
        .rsp_ready  (rsp.ready),
        .rsp_valid  (rsp.valid),
        .rsp_status (rsp.status),
        .rsp_value  (rsp.out_value),
        .rsp_count  (rsp.out_count)
    );

endmodule

/* rtl/rcst_dpath.sv */
// Datapath of the sorted table: entry memory, search bounds, shift
// pointer, entry counter and the response register.
// Depends on rcst_pkg.
module rcst_dpath import rcst_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  dp_cmd_t           cmd,
    output dp_stat_t          stat,
    input  logic [OP_W-1:0]   req_op,
    input  logic [KEY_W-1:0]  req_key,
    input  logic [VAL_W-1:0]  req_value,
    input  logic [ICNT_W-1:0] req_count,
    input  logic              rsp_ready,
    output logic              rsp_valid,
    output logic [ST_W-1:0]   rsp_status,
    output logic [VAL_W-1:0]  rsp_value,
    output logic [ICNT_W-1:0] rsp_count
);

    // Entry memory, one write and one registered read port
    entry_t mem [CAPACITY];
    entry_t rd_data_reg;

    // Control registers
    logic [CNT_W-1:0] used_reg;
    logic             rsp_valid_reg;

    // Payload registers
    op_t               op_reg;
    logic [KEY_W-1:0]  key_reg;
    logic [VAL_W-1:0]  val_reg;
    logic [ICNT_W-1:0] cnt_reg;
    logic [CNT_W-1:0]  lo_reg;
    logic [CNT_W-1:0]  hi_reg;
    logic [CNT_W-1:0]  j_reg;
    logic              up_reg;
    logic              hit_reg;
    entry_t            sav_reg;
    logic [ST_W-1:0]   rsp_status_reg;
    logic [VAL_W-1:0]  rsp_value_reg;
    logic [ICNT_W-1:0] rsp_count_reg;

    logic [CNT_W:0]   mid_sum;
    logic [CNT_W-1:0] mid;
    logic [CNT_W-1:0] j_dn;
    logic [CNT_W-1:0] j_up;
    logic             rd_en;
    logic [IDX_W-1:0] rd_addr;
    logic             wr_en;
    logic [IDX_W-1:0] wr_addr;
    entry_t           wr_data;
    entry_t           ref_entry;

    // Search midpoint and shift neighbours
    assign mid_sum = {1'b0, lo_reg} + {1'b0, hi_reg};
    assign mid     = mid_sum[CNT_W:1];
    assign j_dn    = j_reg - CNT_W'(1);
    assign j_up    = j_reg + CNT_W'(1);

    // Read port select
    assign rd_en = cmd.search_rd | cmd.shift_rd;
    always_comb
    begin
        if (cmd.search_rd)
        begin
            rd_addr = mid[IDX_W-1:0];
        end
        else if (up_reg)
        begin
            rd_addr = j_dn[IDX_W-1:0];
        end
        else
        begin
            rd_addr = j_up[IDX_W-1:0];
        end
    end

    // Write port select
    always_comb
    begin
        ref_entry = sav_reg;
        ref_entry.refs = cmd.ref_inc ? sav_reg.refs + REF_W'(1)
                                     : sav_reg.refs - REF_W'(1);
        wr_en = cmd.shift_wr | cmd.write_new | cmd.write_ref;
        if (cmd.shift_wr)
        begin
            wr_addr = j_reg[IDX_W-1:0];
            wr_data = rd_data_reg;
        end
        else if (cmd.write_new)
        begin
            wr_addr = lo_reg[IDX_W-1:0];
            wr_data = '{key: key_reg, value: val_reg, count: cnt_reg,
                        refs: REF_W'(1)};
        end
        else
        begin
            wr_addr = lo_reg[IDX_W-1:0];
            wr_data = ref_entry;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    // Entry counter and response valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            used_reg      <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd.write_new)
            begin
                used_reg <= used_reg + CNT_W'(1);
            end
            else if (cmd.used_dec)
            begin
                used_reg <= used_reg - CNT_W'(1);
            end
            if (cmd.load_out)
            begin
                rsp_valid_reg <= 1'b1;
            end
            else if (rsp_ready)
            begin
                rsp_valid_reg <= 1'b0;
            end
        end
    end

    // Request capture, binary search bounds, shift pointer, response payload
    always_ff @(posedge clk)
    begin
        if (cmd.latch_in)
        begin
            op_reg  <= op_t'(req_op);
            key_reg <= req_key;
            val_reg <= req_value;
            cnt_reg <= req_count;
        end
        if (cmd.search_init)
        begin
            lo_reg  <= '0;
            hi_reg  <= used_reg;
            hit_reg <= 1'b0;
        end
        else if (cmd.search_cmp)
        begin
            if (rd_data_reg.key < key_reg)
            begin
                lo_reg <= mid + CNT_W'(1);
            end
            else
            begin
                hi_reg <= mid;
            end
            if (rd_data_reg.key == key_reg)
            begin
                hit_reg <= 1'b1;
                sav_reg <= rd_data_reg;
            end
        end
        if (cmd.shift_init)
        begin
            up_reg <= cmd.shift_up;
            j_reg  <= cmd.shift_up ? used_reg : lo_reg;
        end
        else if (cmd.shift_wr)
        begin
            j_reg <= up_reg ? j_dn : j_up;
        end
        if (cmd.load_out)
        begin
            rsp_status_reg <= cmd.out_status;
            rsp_value_reg  <= (cmd.out_status == ST_HIT) ? sav_reg.value : '0;
            rsp_count_reg  <= (cmd.out_status == ST_HIT) ? sav_reg.count : '0;
        end
    end

    // Status back to the controller
    assign stat.op          = op_reg;
    assign stat.search_done = (lo_reg >= hi_reg);
    assign stat.hit         = hit_reg;
    assign stat.full        = (used_reg == CNT_W'(CAPACITY));
    assign stat.ref_last    = (sav_reg.refs == REF_W'(1));
    assign stat.shift_done  = up_reg ? (j_reg == lo_reg)
                                     : ({1'b0, j_up} >= {1'b0, used_reg});
    assign stat.out_free    = !rsp_valid_reg || rsp_ready;

    assign rsp_valid  = rsp_valid_reg;
    assign rsp_status = rsp_status_reg;
    assign rsp_value  = rsp_value_reg;
    assign rsp_count  = rsp_count_reg;

    // Checks
    a_used_bound: assert property (@(posedge clk) disable iff (!rst_n)
        used_reg <= CNT_W'(CAPACITY))
        else $error("entry count above capacity");

    a_shift_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.shift_wr |-> (j_reg < CNT_W'(CAPACITY)) && (j_reg <= used_reg))
        else $error("shift write outside the table");

    a_new_counts: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.write_new |=> used_reg == $past(used_reg) + CNT_W'(1))
        else $error("insert did not grow the table");

endmodule

/* rtl/rcst_ctrl.sv */
// Controller of the sorted table: sequences search, update, shift and
// response for one request at a time. Depends on rcst_pkg.
module rcst_ctrl import rcst_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     req_valid,
    output logic     req_ready,
    input  dp_stat_t stat,
    output dp_cmd_t  cmd
);

    typedef enum logic [7:0] {
        S_IDLE   = 8'b0000_0001,
        S_RD     = 8'b0000_0010,
        S_CMP    = 8'b0000_0100,
        S_DECIDE = 8'b0000_1000,
        S_SH_RD  = 8'b0001_0000,
        S_SH_WR  = 8'b0010_0000,
        S_FIN    = 8'b0100_0000,
        S_RESP   = 8'b1000_0000
    } state_t;

    state_t  state_reg;
    state_t  state_next;
    status_t code_reg;
    status_t code_next;

    // Next state and commands
    always_comb
    begin
        state_next     = state_reg;
        code_next      = code_reg;
        cmd            = '0;
        cmd.out_status = code_reg;
        req_ready      = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                req_ready = 1'b1;
                if (req_valid)
                begin
                    cmd.latch_in    = 1'b1;
                    cmd.search_init = 1'b1;
                    state_next      = S_RD;
                end
            end
            S_RD:
            begin
                if (stat.search_done)
                begin
                    state_next = S_DECIDE;
                end
                else
                begin
                    cmd.search_rd = 1'b1;
                    state_next    = S_CMP;
                end
            end
            S_CMP:
            begin
                cmd.search_cmp = 1'b1;
                state_next     = S_RD;
            end
            S_DECIDE:
            begin
                state_next = S_RESP;
                case (stat.op)
                    OP_INSERT:
                    begin
                        if (stat.hit)
                        begin
                            cmd.write_ref = 1'b1;
                            cmd.ref_inc   = 1'b1;
                            code_next     = ST_BUMPED;
                        end
                        else if (stat.full)
                        begin
                            code_next = ST_FULL;
                        end
                        else
                        begin
                            cmd.shift_init = 1'b1;
                            cmd.shift_up   = 1'b1;
                            state_next     = S_SH_RD;
                        end
                    end
                    OP_REMOVE:
                    begin
                        if (!stat.hit)
                        begin
                            code_next = ST_ABSENT;
                        end
                        else if (!stat.ref_last)
                        begin
                            cmd.write_ref = 1'b1;
                            code_next     = ST_HELD;
                        end
                        else
                        begin
                            cmd.shift_init = 1'b1;
                            state_next     = S_SH_RD;
                        end
                    end
                    OP_LOOKUP:
                    begin
                        code_next = stat.hit ? ST_HIT : ST_MISS;
                    end
                    default:
                    begin
                        code_next = ST_MISS;
                    end
                endcase
            end
            S_SH_RD:
            begin
                if (stat.shift_done)
                begin
                    state_next = S_FIN;
                end
                else
                begin
                    cmd.shift_rd = 1'b1;
                    state_next   = S_SH_WR;
                end
            end
            S_SH_WR:
            begin
                cmd.shift_wr = 1'b1;
                state_next   = S_SH_RD;
            end
            S_FIN:
            begin
                // Insert drops the new entry into the opened slot
                if (stat.op == OP_INSERT)
                begin
                    cmd.write_new = 1'b1;
                    code_next     = ST_ADDED;
                end
                else
                begin
                    cmd.used_dec = 1'b1;
                    code_next    = ST_FREED;
                end
                state_next = S_RESP;
            end
            S_RESP:
            begin
                if (stat.out_free)
                begin
                    cmd.load_out = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            code_reg  <= ST_MISS;
        end
        else
        begin
            state_reg <= state_next;
            code_reg  <= code_next;
        end
    end

    // Checks
    a_resp_waits: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_RESP && !stat.out_free) |=> state_reg == S_RESP)
        else $error("response dropped while output register busy");

    a_no_add_when_full: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.write_new |-> !stat.full)
        else $error("new entry written into a full table");

    a_lookup_no_shift: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_DECIDE && stat.op == OP_LOOKUP) |=> state_reg == S_RESP)
        else $error("lookup went past the decide step");

endmodule
